// ===== rtl/tdisp_pkg.sv =====
// Shared types and constants of the typed job dispatcher.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none
package tdisp_pkg;

    localparam int NUM_TYPES_DEF   = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int OUTSTANDING_DEF = 64;

    localparam int ACT_W   = 3;
    localparam int TYPE_W  = 2;
    localparam int ID_W    = 16;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int MAXQ_W  = 5;
    localparam logic [MAXQ_W-1:0] MAXQ_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_SUBMIT   = 3'd0,
        ACT_ABORT    = 3'd1,
        ACT_GET_WORK = 3'd2,
        ACT_QUERY    = 3'd3,
        ACT_PROVIDE  = 3'd4,
        ACT_GET_NEXT = 3'd5,
        ACT_STOP     = 3'd6
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_STOPPED = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch;
        logic    rq_t_clr;
        logic    rq_i_inc;
        logic    rq_t_next;
        logic    rq_rd;
        logic    rq_rd_next;
        logic    rq_wr_shift;
        logic    rq_cnt_dec;
        logic    rq_push;
        logic    is_ptr_clr;
        logic    is_ptr_inc;
        logic    is_rd;
        logic    is_rd_next;
        logic    is_wr_shift;
        logic    is_wr_result;
        logic    is_cnt_dec;
        logic    is_push;
        logic    res_status_en;
        t_status res_status;
        logic    res_submit;
        logic    res_work;
        logic    res_next;
        logic    res_keep;
        logic    set_stop;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic stopped;
        logic type_ok;
        logic rq_full;
        logic rq_empty;
        logic rq_i_end;
        logic rq_i_last;
        logic rq_t_last;
        logic rq_hit;
        logic is_full;
        logic is_end;
        logic is_last;
        logic is_hit;
        logic is_rvalid;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/tdisp_ifs.sv =====
// Handshake channels of the dispatcher: request words, response words, config.
// Depends on tdisp_pkg for field widths.
`default_nettype none
interface tdisp_in_if;
    logic                           valid;
    logic                           ready;
    logic [tdisp_pkg::ACT_W-1:0]    action;
    logic [tdisp_pkg::TYPE_W-1:0]   job_type;
    logic [tdisp_pkg::ID_W-1:0]     job_id;
    logic [tdisp_pkg::DATA_W-1:0]   data_in;
    modport source (output valid, action, job_type, job_id, data_in, input ready);
    modport sink (input valid, action, job_type, job_id, data_in, output ready);
endinterface

interface tdisp_out_if;
    logic                           valid;
    logic                           ready;
    logic [tdisp_pkg::STAT_W-1:0]   status;
    logic [tdisp_pkg::ID_W-1:0]     id_out;
    logic [tdisp_pkg::TYPE_W-1:0]   type_out;
    logic [tdisp_pkg::DATA_W-1:0]   data_out;
    logic                           keep_going;
    modport source (output valid, status, id_out, type_out, data_out, keep_going,
                    input ready);
    modport sink (input valid, status, id_out, type_out, data_out, keep_going,
                  output ready);
endinterface

interface tdisp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tdisp_pkg::MAXQ_W-1:0]   max_queue;
    modport source (output valid, max_queue, input ready);
    modport sink (input valid, max_queue, output ready);
endinterface
`default_nettype wire

// ===== rtl/tdisp_dp.sv =====
// Datapath: per-type request queues, issue order with attached results,
// counters, flags and the response register. Depends on tdisp_pkg.
`default_nettype none
module tdisp_dp #(
    parameter int NUM_TYPES   = tdisp_pkg::NUM_TYPES_DEF,
    parameter int QUEUE_DEPTH = tdisp_pkg::QUEUE_DEPTH_DEF,
    parameter int OUTSTANDING = tdisp_pkg::OUTSTANDING_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tdisp_pkg::t_cmd               i_cmd,
    output tdisp_pkg::t_dp_stat                o_stat,
    input  wire logic [tdisp_pkg::ACT_W-1:0]   i_action,
    input  wire logic [tdisp_pkg::TYPE_W-1:0]  i_job_type,
    input  wire logic [tdisp_pkg::ID_W-1:0]    i_job_id,
    input  wire logic [tdisp_pkg::DATA_W-1:0]  i_data_in,
    input  wire logic                          i_cfg_wr,
    input  wire logic [tdisp_pkg::MAXQ_W-1:0]  i_max_queue,
    output logic [tdisp_pkg::STAT_W-1:0]       o_status,
    output logic [tdisp_pkg::ID_W-1:0]         o_id_out,
    output logic [tdisp_pkg::TYPE_W-1:0]       o_type_out,
    output logic [tdisp_pkg::DATA_W-1:0]       o_data_out,
    output logic                               o_keep_going
);

    localparam int TW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int RAW  = (NUM_TYPES * QUEUE_DEPTH > 1) ? $clog2(NUM_TYPES * QUEUE_DEPTH) : 1;
    localparam int IW   = $clog2(OUTSTANDING + 1);
    localparam int IXW  = $clog2(OUTSTANDING);
    localparam int RQ_N = NUM_TYPES * QUEUE_DEPTH;

    typedef struct packed {
        logic [tdisp_pkg::ID_W-1:0]   id;
        logic [tdisp_pkg::DATA_W-1:0] data;
    } t_req;

    typedef struct packed {
        logic [tdisp_pkg::ID_W-1:0]   id;
        logic                         rvalid;
        logic [tdisp_pkg::DATA_W-1:0] data;
    } t_iss;

    function automatic logic [RAW-1:0] rq_addr(input logic [TW-1:0] t,
                                               input logic [QIW-1:0] i);
        return RAW'(32'(t) * 32'(QUEUE_DEPTH) + 32'(i));
    endfunction

    // Latched request word
    logic [tdisp_pkg::ACT_W-1:0]  r_act;
    logic [tdisp_pkg::TYPE_W-1:0] r_type;
    logic [tdisp_pkg::ID_W-1:0]   r_id;
    logic [tdisp_pkg::DATA_W-1:0] r_data;

    logic [tdisp_pkg::MAXQ_W-1:0] r_max_queue;
    logic                         r_stopped;
    logic [tdisp_pkg::ID_W-1:0]   r_next_id;

    logic [CW-1:0]  r_rq_cnt [NUM_TYPES];
    logic [TW-1:0]  r_t;
    logic [CW-1:0]  r_i;
    t_req           rq_mem [RQ_N];
    t_req           r_rq_rdata;

    logic [IW-1:0]  r_icnt;
    logic [IW-1:0]  r_ptr;
    t_iss           is_mem [OUTSTANDING];
    t_iss           r_is_rdata;

    logic [tdisp_pkg::STAT_W-1:0] r_status;
    logic [tdisp_pkg::ID_W-1:0]   r_id_out;
    logic [tdisp_pkg::TYPE_W-1:0] r_type_out;
    logic [tdisp_pkg::DATA_W-1:0] r_data_out;
    logic                         r_keep;

    logic           type_ok_in;
    logic           type_ok;
    logic [CW-1:0]  cnt_t;
    logic [CW-1:0]  i_plus;
    logic [IW-1:0]  ptr_plus;
    logic [15:0]    limit;

    // Decode the queue a word refers to and the queue limit
    always_comb begin
        type_ok_in = 4'(i_job_type) < 4'(NUM_TYPES);
        type_ok    = 4'(r_type) < 4'(NUM_TYPES);
        cnt_t      = r_rq_cnt[r_t];
        i_plus     = r_i + CW'(1);
        ptr_plus   = r_ptr + IW'(1);
        limit      = (16'(r_max_queue) < 16'(QUEUE_DEPTH)) ? 16'(r_max_queue)
                                                          : 16'(QUEUE_DEPTH);
    end

    always_comb begin
        o_stat.act       = r_act;
        o_stat.stopped   = r_stopped;
        o_stat.type_ok   = type_ok;
        o_stat.rq_full   = 16'(cnt_t) >= limit;
        o_stat.rq_empty  = cnt_t == '0;
        o_stat.rq_i_end  = r_i >= cnt_t;
        o_stat.rq_i_last = 16'(r_i) + 16'd1 >= 16'(cnt_t);
        o_stat.rq_t_last = 32'(r_t) == 32'(NUM_TYPES - 1);
        o_stat.rq_hit    = r_rq_rdata.id == r_id;
        o_stat.is_full   = 32'(r_icnt) >= 32'(OUTSTANDING);
        o_stat.is_end    = r_ptr >= r_icnt;
        o_stat.is_last   = 32'(r_ptr) + 32'd1 >= 32'(r_icnt);
        o_stat.is_hit    = r_is_rdata.id == r_id;
        o_stat.is_rvalid = r_is_rdata.rvalid;
    end

    // Control registers: counters, pointers, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_queue <= tdisp_pkg::MAXQ_RESET;
            r_stopped   <= 1'b0;
            r_next_id   <= '0;
            r_icnt      <= '0;
            r_ptr       <= '0;
            r_t         <= '0;
            r_i         <= '0;
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_rq_cnt[k] <= '0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_max_queue <= i_max_queue;
            end
            if (i_cmd.set_stop) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_t   <= type_ok_in ? TW'(4'(i_job_type)) : '0;
                r_i   <= '0;
                r_ptr <= '0;
            end
            if (i_cmd.rq_t_clr) begin
                r_t <= '0;
                r_i <= '0;
            end
            if (i_cmd.rq_t_next) begin
                r_t <= r_t + TW'(1);
                r_i <= '0;
            end
            if (i_cmd.rq_i_inc) begin
                r_i <= i_plus;
            end
            if (i_cmd.rq_push) begin
                r_rq_cnt[r_t] <= cnt_t + CW'(1);
                r_next_id     <= r_next_id + 16'd1;
            end
            if (i_cmd.rq_cnt_dec) begin
                r_rq_cnt[r_t] <= cnt_t - CW'(1);
            end
            if (i_cmd.is_push) begin
                r_icnt <= r_icnt + IW'(1);
            end
            if (i_cmd.is_cnt_dec) begin
                r_icnt <= r_icnt - IW'(1);
            end
            if (i_cmd.is_ptr_clr) begin
                r_ptr <= '0;
            end
            if (i_cmd.is_ptr_inc) begin
                r_ptr <= ptr_plus;
            end
        end
    end

    // Latch the request word and build the response word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act      <= i_action;
            r_type     <= i_job_type;
            r_id       <= i_job_id;
            r_data     <= i_data_in;
            r_status   <= tdisp_pkg::ST_OK;
            r_id_out   <= '0;
            r_type_out <= '0;
            r_data_out <= '0;
            r_keep     <= 1'b0;
        end
        if (i_cmd.res_status_en) begin
            r_status <= i_cmd.res_status;
        end
        if (i_cmd.res_submit) begin
            r_id_out <= r_next_id;
        end
        if (i_cmd.res_work) begin
            r_id_out   <= r_rq_rdata.id;
            r_data_out <= r_rq_rdata.data;
            r_type_out <= r_type;
        end
        if (i_cmd.res_next) begin
            r_id_out   <= r_is_rdata.id;
            r_data_out <= r_is_rdata.data;
        end
        if (i_cmd.res_keep) begin
            r_keep <= !r_stopped;
        end
    end

    // Request queue memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.rq_push) begin
            rq_mem[rq_addr(r_t, cnt_t[QIW-1:0])] <= '{id: r_next_id, data: r_data};
        end else if (i_cmd.rq_wr_shift) begin
            rq_mem[rq_addr(r_t, r_i[QIW-1:0])] <= r_rq_rdata;
        end
        if (i_cmd.rq_rd) begin
            r_rq_rdata <= rq_mem[rq_addr(r_t, r_i[QIW-1:0])];
        end else if (i_cmd.rq_rd_next) begin
            r_rq_rdata <= rq_mem[rq_addr(r_t, i_plus[QIW-1:0])];
        end
    end

    // Issue order memory: each entry carries its result once it arrives
    always_ff @(posedge i_clk) begin
        if (i_cmd.is_push) begin
            is_mem[r_icnt[IXW-1:0]] <= '{id: r_next_id, rvalid: 1'b0, data: '0};
        end else if (i_cmd.is_wr_shift) begin
            is_mem[r_ptr[IXW-1:0]] <= r_is_rdata;
        end else if (i_cmd.is_wr_result) begin
            is_mem[r_ptr[IXW-1:0]] <= '{id: r_id, rvalid: 1'b1, data: r_data};
        end
        if (i_cmd.is_rd) begin
            r_is_rdata <= is_mem[r_ptr[IXW-1:0]];
        end else if (i_cmd.is_rd_next) begin
            r_is_rdata <= is_mem[ptr_plus[IXW-1:0]];
        end
    end

    assign o_status     = r_status;
    assign o_id_out     = r_id_out;
    assign o_type_out   = r_type_out;
    assign o_data_out   = r_data_out;
    assign o_keep_going = r_keep;

endmodule
`default_nettype wire

// ===== rtl/tdisp_ctrl.sv =====
// Controller: sequences decode, queue scans and shifts, and the response.
// Depends on tdisp_pkg for the command and status structs.
`default_nettype none
module tdisp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire tdisp_pkg::t_dp_stat  i_stat,
    output tdisp_pkg::t_cmd           o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_GW_CK, S_RQ_SCRD, S_RQ_SCCK, S_RQ_SHRD, S_RQ_SHWR,
        S_IS_SCRD, S_IS_SCCK, S_GN_CK, S_IS_SHRD, S_IS_SHWR, S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_RESP;
                case (i_stat.act)
                    tdisp_pkg::ACT_SUBMIT: begin
                        o_cmd.res_status_en = 1'b1;
                        if (i_stat.stopped) begin
                            o_cmd.res_status = tdisp_pkg::ST_STOPPED;
                        end else if (!i_stat.type_ok || i_stat.rq_full || i_stat.is_full) begin
                            o_cmd.res_status = tdisp_pkg::ST_FULL;
                        end else begin
                            o_cmd.res_status = tdisp_pkg::ST_OK;
                            o_cmd.rq_push    = 1'b1;
                            o_cmd.is_push    = 1'b1;
                            o_cmd.res_submit = 1'b1;
                        end
                    end
                    tdisp_pkg::ACT_ABORT: begin
                        o_cmd.rq_t_clr = 1'b1;
                        n_state        = S_RQ_SCRD;
                    end
                    tdisp_pkg::ACT_GET_WORK: begin
                        if (i_stat.stopped) begin
                            o_cmd.res_status_en = 1'b1;
                            o_cmd.res_status    = tdisp_pkg::ST_STOPPED;
                        end else if (!i_stat.type_ok || i_stat.rq_empty) begin
                            o_cmd.res_status_en = 1'b1;
                            o_cmd.res_status    = tdisp_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rq_rd = 1'b1;
                            n_state     = S_GW_CK;
                        end
                    end
                    tdisp_pkg::ACT_QUERY, tdisp_pkg::ACT_PROVIDE: begin
                        o_cmd.is_ptr_clr = 1'b1;
                        n_state          = S_IS_SCRD;
                    end
                    tdisp_pkg::ACT_GET_NEXT: begin
                        if (i_stat.stopped) begin
                            o_cmd.res_status_en = 1'b1;
                            o_cmd.res_status    = tdisp_pkg::ST_STOPPED;
                        end else if (i_stat.is_end) begin
                            o_cmd.res_status_en = 1'b1;
                            o_cmd.res_status    = tdisp_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.is_rd = 1'b1;
                            n_state     = S_GN_CK;
                        end
                    end
                    tdisp_pkg::ACT_STOP: begin
                        o_cmd.set_stop = 1'b1;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            // Hand out the head job, then close the gap it leaves
            S_GW_CK: begin
                o_cmd.res_work = 1'b1;
                n_state        = S_RQ_SHRD;
            end
            // Search the type queues in order for the aborted id
            S_RQ_SCRD: begin
                if (i_stat.rq_i_end) begin
                    if (i_stat.rq_t_last) begin
                        o_cmd.is_ptr_clr = 1'b1;
                        n_state          = S_IS_SCRD;
                    end else begin
                        o_cmd.rq_t_next = 1'b1;
                    end
                end else begin
                    o_cmd.rq_rd = 1'b1;
                    n_state     = S_RQ_SCCK;
                end
            end
            S_RQ_SCCK: begin
                if (i_stat.rq_hit) begin
                    n_state = S_RQ_SHRD;
                end else begin
                    o_cmd.rq_i_inc = 1'b1;
                    n_state        = S_RQ_SCRD;
                end
            end
            // Shift the queue down one entry at a time
            S_RQ_SHRD: begin
                if (i_stat.rq_i_last) begin
                    o_cmd.rq_cnt_dec = 1'b1;
                    if (i_stat.act == tdisp_pkg::ACT_ABORT) begin
                        o_cmd.is_ptr_clr = 1'b1;
                        n_state          = S_IS_SCRD;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    o_cmd.rq_rd_next = 1'b1;
                    n_state          = S_RQ_SHWR;
                end
            end
            S_RQ_SHWR: begin
                o_cmd.rq_wr_shift = 1'b1;
                o_cmd.rq_i_inc    = 1'b1;
                n_state           = S_RQ_SHRD;
            end
            // Search the issue order for the first entry with the id
            S_IS_SCRD: begin
                if (i_stat.is_end) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.is_rd = 1'b1;
                    n_state     = S_IS_SCCK;
                end
            end
            S_IS_SCCK: begin
                if (i_stat.is_hit) begin
                    n_state = S_RESP;
                    case (i_stat.act)
                        tdisp_pkg::ACT_ABORT:   n_state = S_IS_SHRD;
                        tdisp_pkg::ACT_QUERY:   o_cmd.res_keep = 1'b1;
                        tdisp_pkg::ACT_PROVIDE: o_cmd.is_wr_result = 1'b1;
                        default:                n_state = S_RESP;
                    endcase
                end else begin
                    o_cmd.is_ptr_inc = 1'b1;
                    n_state          = S_IS_SCRD;
                end
            end
            // Release the oldest result only once it has arrived
            S_GN_CK: begin
                if (!i_stat.is_rvalid) begin
                    o_cmd.res_status_en = 1'b1;
                    o_cmd.res_status    = tdisp_pkg::ST_EMPTY;
                    n_state             = S_RESP;
                end else begin
                    o_cmd.res_next = 1'b1;
                    n_state        = S_IS_SHRD;
                end
            end
            S_IS_SHRD: begin
                if (i_stat.is_last) begin
                    o_cmd.is_cnt_dec = 1'b1;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.is_rd_next = 1'b1;
                    n_state          = S_IS_SHWR;
                end
            end
            S_IS_SHWR: begin
                o_cmd.is_wr_shift = 1'b1;
                o_cmd.is_ptr_inc  = 1'b1;
                n_state           = S_IS_SHRD;
            end
            // Hold the response word until it is taken
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_RESP;

endmodule
`default_nettype wire

// ===== rtl/typed_dispatch_with_inorder_results.sv =====
// Top level of the typed job dispatcher: controller plus datapath.
// Depends on tdisp_pkg, tdisp_ifs, tdisp_ctrl and tdisp_dp.
//
// One request word is handled at a time and answered with exactly one
// response word. Submit, stop and refused or stopped requests go from
// decode straight to the response. Get work reads the head of its type's
// queue, hands it out, then shifts the rest of that queue down one entry
// at a time. Get next result reads the oldest issue-order entry; if its
// result has not arrived it answers empty, else it releases the result and
// shifts the issue order down. Abort searches the type queues and then the
// issue order for the id, removing the first entry found in each; continue
// query and provide result search only the issue order. Each entry is
// walked with a read and then a check or a write. The max_queue register
// is written through the config channel, which is always ready; write it
// only while idle.
`default_nettype none
module typed_dispatch_with_inorder_results #(
    parameter int NUM_TYPES   = tdisp_pkg::NUM_TYPES_DEF,
    parameter int QUEUE_DEPTH = tdisp_pkg::QUEUE_DEPTH_DEF,
    parameter int OUTSTANDING = tdisp_pkg::OUTSTANDING_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tdisp_in_if.sink     i_in,
    tdisp_out_if.source  o_out,
    tdisp_cfg_if.sink    i_cfg
);

    tdisp_pkg::t_cmd     cmd;
    tdisp_pkg::t_dp_stat stat;
    logic                in_ready;
    logic                out_valid;

    tdisp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tdisp_dp #(
        .NUM_TYPES   (NUM_TYPES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .OUTSTANDING (OUTSTANDING)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_in.action),
        .i_job_type   (i_in.job_type),
        .i_job_id     (i_in.job_id),
        .i_data_in    (i_in.data_in),
        .i_cfg_wr     (i_cfg.valid),
        .i_max_queue  (i_cfg.max_queue),
        .o_status     (o_out.status),
        .o_id_out     (o_out.id_out),
        .o_type_out   (o_out.type_out),
        .o_data_out   (o_out.data_out),
        .o_keep_going (o_out.keep_going)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

endmodule
`default_nettype wire
